### sv/pbam_pkg.sv
// Package: shared types and constants of the paged bus address mapper.
`timescale 1ns / 1ps
package pbam_pkg;

  localparam int unsigned AddrW    = 16;
  localparam int unsigned DataW    = 8;
  localparam int unsigned PageW    = 5;
  localparam int unsigned RamAddrW = 19;
  localparam int unsigned OffsW    = 14;
  localparam int unsigned Pages    = 8;

  // device select codes
  localparam logic [2:0] SEL_RAM  = 3'd0;
  localparam logic [2:0] SEL_ROM0 = 3'd1;
  localparam logic [2:0] SEL_ROM1 = 3'd2;  // also vectors
  localparam logic [2:0] SEL_ROM2 = 3'd3;
  localparam logic [2:0] SEL_IO0  = 3'd4;
  localparam logic [2:0] SEL_IO1  = 3'd5;
  localparam logic [2:0] SEL_IO2  = 3'd6;
  localparam logic [2:0] SEL_NONE = 3'd7;

  // control register area, indexed by address bits 4..1
  localparam logic [3:0] REG_TASK  = 4'hA;
  localparam logic [3:0] REG_RATE0 = 4'hB;
  localparam logic [3:0] REG_RATE1 = 4'hC;
  localparam logic [3:0] REG_MAP   = 4'hF;

  // page register area, indexed by address bits 3..0
  localparam logic [3:0] PREG_COMMON = 4'hF;

  // access lengths in 14.31818 MHz ticks
  localparam logic [4:0] TICKS_SLOW      = 5'd16;
  localparam logic [4:0] TICKS_TO_FAST   = 5'd15;
  localparam logic [4:0] TICKS_TO_SLOW   = 5'd17;
  localparam logic [4:0] TICKS_TO_SLOW_X = 5'd25;
  localparam logic [4:0] TICKS_FAST      = 5'd8;

  localparam logic [PageW-1:0] PAGE_COMMON = 5'd31;

  localparam logic [Pages-1:0][PageW-1:0] PAGE_RESET = {
    5'd3, 5'd2, 5'd3, 5'd2, 5'd3, 5'd2, 5'd1, 5'd0
  };

  typedef struct packed {
    logic                         task_select;
    logic                         rate_fast;
    logic                         map_type_all_ram;
    logic [1:0]                   common_flags;
    logic [Pages-1:0][PageW-1:0]  page_table;
    logic                         fast_phase;
    logic                         extend_slow;
  } state_t;

  localparam state_t STATE_RESET = '{
    task_select:      1'b0,
    rate_fast:        1'b0,
    map_type_all_ram: 1'b0,
    common_flags:     2'b00,
    page_table:       PAGE_RESET,
    fast_phase:       1'b0,
    extend_slow:      1'b0
  };

  typedef struct packed {
    logic                read_not_write;
    logic [AddrW-1:0]    address;
    logic [DataW-1:0]    data_in;
  } access_t;

  typedef struct packed {
    logic [2:0]          select_code;
    logic [RamAddrW-1:0] ram_address;
    logic                ram_enable;
    logic                write_enable_n;
    logic                task_read;
    logic                task_bit;
    logic [4:0]          cycle_ticks;
  } result_t;

endpackage

### sv/pbam_in_if.sv
// Interface: bus access channel into the mapper.
`timescale 1ns / 1ps
interface pbam_in_if
  import pbam_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             read_not_write;
  logic [AddrW-1:0] address;
  logic [DataW-1:0] data_in;

  modport source (output valid, output read_not_write, output address, output data_in,
                  input ready);
  modport sink   (input valid, input read_not_write, input address, input data_in,
                  output ready);
endinterface

### sv/pbam_out_if.sv
// Interface: decode result channel out of the mapper.
`timescale 1ns / 1ps
interface pbam_out_if
  import pbam_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [2:0]          select_code;
  logic [RamAddrW-1:0] ram_address;
  logic                ram_enable;
  logic                write_enable_n;
  logic                task_read;
  logic                task_bit;
  logic [4:0]          cycle_ticks;

  modport source (output valid, output select_code, output ram_address, output ram_enable,
                  output write_enable_n, output task_read, output task_bit,
                  output cycle_ticks, input ready);
  modport sink   (input valid, input select_code, input ram_address, input ram_enable,
                  input write_enable_n, input task_read, input task_bit,
                  input cycle_ticks, output ready);
endinterface

### sv/paged_bus_address_mapper_top.sv
// A result word is registered in the output buffer; it waits in the skid stage while the output register is full.
// Throughput: one access per cycle while the output buffer has room; decode, page table read and timing update
// all sit between the accepted word and the output register.
// A two-word output buffer keeps accepting while one result waits to be taken.
// Reset (async, active low): task 0, slow rate, ROM map, no common windows,
// page table 0,1,2,3,2,3,2,3, interleave phase slow; output buffer empty.
`timescale 1ns / 1ps
module paged_bus_address_mapper_top
  import pbam_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  pbam_in_if.sink           req_i,
  pbam_out_if.source        rsp_o
);

  access_t acc;
  state_t  state_q, state_d;
  result_t res, res_q;
  logic    accept;
  logic    buf_ready;

  assign acc.read_not_write = req_i.read_not_write;
  assign acc.address        = req_i.address;
  assign acc.data_in        = req_i.data_in;
  assign req_i.ready        = buf_ready;
  assign accept             = req_i.valid && buf_ready;

  pbam_decode u_decode (
    .acc_i   (acc),
    .state_i (state_q),
    .state_o (state_d),
    .res_o   (res)
  );

  pbam_state u_state (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (accept),
    .state_d_i (state_d),
    .state_q_o (state_q)
  );

  pbam_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (res),
    .ready_o (buf_ready),
    .valid_o (rsp_o.valid),
    .ready_i (rsp_o.ready),
    .data_o  (res_q)
  );

  assign rsp_o.select_code    = res_q.select_code;
  assign rsp_o.ram_address    = res_q.ram_address;
  assign rsp_o.ram_enable     = res_q.ram_enable;
  assign rsp_o.write_enable_n = res_q.write_enable_n;
  assign rsp_o.task_read      = res_q.task_read;
  assign rsp_o.task_bit       = res_q.task_bit;
  assign rsp_o.cycle_ticks    = res_q.cycle_ticks;

endmodule

### sv/pbam_decode.sv
// Decode: select, register writes, page translation and interleave timing.
`timescale 1ns / 1ps
module pbam_decode
  import pbam_pkg::*;
(
  input  access_t acc_i,
  input  state_t  state_i,
  output state_t  state_o,
  output result_t res_o
);

  logic [15:0] a;
  logic [2:0]  top3;
  logic [2:0]  sub;
  logic [3:0]  nib;
  logic [3:0]  regi;
  logic        ffxx, io0, io1, ff3x, io2, sreg, vec;
  logic        c0, c1, common, ty, is_ram, wr;
  logic [2:0]  sel;
  logic [2:0]  pidx;
  logic [PageW-1:0] page;
  logic [4:0]  ticks;
  state_t      nxt;

  assign a    = acc_i.address;
  assign wr   = !acc_i.read_not_write;
  assign top3 = a[15:13];
  assign sub  = a[7:5];
  assign nib  = a[7:4];
  assign regi = a[4:1];
  assign ffxx = (a[15:8] == 8'hFF);
  assign io0  = ffxx && (sub == 3'd0);
  assign io1  = ffxx && (nib == 4'd2);
  assign ff3x = ffxx && (nib == 4'd3);
  assign io2  = ffxx && (sub == 3'd2);
  assign sreg = ffxx && (sub == 3'd6);
  assign vec  = ffxx && (sub == 3'd7);
  assign c0   = state_i.common_flags[0] && (a[15:12] == 4'hF);
  assign c1   = state_i.common_flags[1] && (a[15:12] == 4'hE);
  // common windows skip the I/O and register pages but cover the vectors
  assign common = (c0 || c1) && (vec || !ffxx);
  assign ty     = state_i.map_type_all_ram;
  assign is_ram = !a[15] || (ty && !ffxx);

  always_comb begin
    priority if (io0)                        sel = SEL_IO0;
    else if (io1)                            sel = SEL_IO1;
    else if (io2)                            sel = SEL_IO2;
    else if (common)                         sel = SEL_RAM;
    else if (vec)                            sel = SEL_ROM1;
    else if (ffxx)                           sel = SEL_NONE;
    else if (!ty && top3 == 3'd4)            sel = SEL_ROM0;
    else if (!ty && top3 == 3'd5)            sel = SEL_ROM1;
    else if (!ty && a[15:14] == 2'd3)        sel = SEL_ROM2;
    else                                     sel = SEL_RAM;
  end

  always_comb begin
    nxt = state_i;
    if (sreg && wr) begin
      priority if (regi == REG_TASK)                        nxt.task_select = a[0];
      else if (regi == REG_RATE0 || regi == REG_RATE1)      nxt.rate_fast = a[0];
      else if (regi == REG_MAP)                             nxt.map_type_all_ram = a[0];
      else                                                  nxt.task_select = state_i.task_select;
    end
    if (ff3x && wr) begin
      priority if (!a[3])                   nxt.page_table[a[2:0]] = acc_i.data_in[PageW-1:0];
      else if (a[3:0] == PREG_COMMON)       nxt.common_flags = acc_i.data_in[1:0];
      else                                  nxt.common_flags = state_i.common_flags;
    end

    // interleave timing uses the rate from before this access
    if (!state_i.fast_phase) begin
      if (!state_i.rate_fast) begin
        ticks = TICKS_SLOW;
      end else begin
        ticks = TICKS_TO_FAST;
        nxt.fast_phase = 1'b1;
      end
    end else if (!state_i.rate_fast) begin
      if (!state_i.extend_slow) begin
        ticks = TICKS_TO_SLOW;
      end else begin
        ticks = TICKS_TO_SLOW_X;
        nxt.extend_slow = 1'b0;
      end
      nxt.fast_phase = 1'b0;
    end else begin
      ticks = TICKS_FAST;
      nxt.extend_slow = !state_i.extend_slow;
    end
  end

  // translation sees this access's own register writes
  assign pidx = {nxt.task_select, a[15:14]};
  assign page = common ? PAGE_COMMON : nxt.page_table[pidx];

  assign state_o            = nxt;
  assign res_o.select_code    = sel;
  assign res_o.ram_address    = {page, a[OffsW-1:0]};
  assign res_o.ram_enable     = is_ram || common;
  assign res_o.write_enable_n = is_ram ? acc_i.read_not_write : 1'b1;
  assign res_o.task_read      = acc_i.read_not_write && sreg && (regi == REG_TASK);
  assign res_o.task_bit       = nxt.task_select;
  assign res_o.cycle_ticks    = ticks;

endmodule

### sv/pbam_state.sv
// Mapper state registers: task, rate, map type, common windows, page table, interleave phase.
`timescale 1ns / 1ps
module pbam_state
  import pbam_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  state_t state_d_i,
  output state_t state_q_o
);

  state_t state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
    end else if (en_i) begin
      state_q <= state_d_i;
    end
  end

  assign state_q_o = state_q;

endmodule

### sv/pbam_out_buf.sv
// Output register with skid stage for decode result words.
`timescale 1ns / 1ps
module pbam_out_buf
  import pbam_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  output logic    ready_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t data_o
);

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop     = out_valid_q && ready_i;
  assign ready_o = !skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_d       = data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_q;

endmodule

### sim/paged_bus_address_mapper_top_tb.sv
// Testbench: drives bus access words into the paged address mapper and checks every decode word.
`timescale 1ns / 1ps
module paged_bus_address_mapper_top_tb;
  import pbam_pkg::*;

  localparam int unsigned RANDOM_WORDS   = 600;
  localparam int unsigned RX_HOLD_CYCLES = 40;
  localparam int unsigned STUCK_LIMIT    = 1000;
  localparam int unsigned TAIL_CYCLES    = 4;
  localparam int unsigned MAX_PRINTED    = 50;

  // Tracks the mapper state and holds the decode words still owed by the block.
  class mapper_scoreboard;
    logic             task_sel;
    logic             fast_rate;
    logic             all_ram;
    logic [1:0]       common_en;
    logic [PageW-1:0] pages [Pages];
    logic             in_fast;
    logic             ext_slow;
    result_t          expected_decodes [$];
    int unsigned      mismatches;
    int unsigned      words_seen;

    function new();
      task_sel  = 1'b0;
      fast_rate = 1'b0;
      all_ram   = 1'b0;
      common_en = 2'b00;
      foreach (pages[i]) pages[i] = PAGE_RESET[i];
      in_fast   = 1'b0;
      ext_slow  = 1'b0;
      mismatches = 0;
      words_seen = 0;
    endfunction

    function int unsigned pending();
      return expected_decodes.size();
    endfunction

    function void note_access(access_t acc);
      logic [AddrW-1:0] a;
      logic             rnw;
      logic             ffxx, sreg, vec, ff3x, common, is_ram, was_fast;
      logic [3:0]       reg_idx;
      logic [2:0]       sel;
      logic [PageW-1:0] page;
      logic [4:0]       ticks;
      result_t          want;
      a        = acc.address;
      rnw      = acc.read_not_write;
      ffxx     = (a[15:8] == 8'hFF);
      sreg     = ffxx && (a[7:5] == 3'd6);
      vec      = ffxx && (a[7:5] == 3'd7);
      ff3x     = ffxx && (a[7:4] == 4'h3);
      reg_idx  = a[4:1];
      common   = ((common_en[0] && a[15:12] == 4'hF) || (common_en[1] && a[15:12] == 4'hE))
                 && (vec || !ffxx);
      is_ram   = !a[15] || (all_ram && !ffxx);
      was_fast = fast_rate;

      if (ffxx && a[7:5] == 3'd0) sel = SEL_IO0;
      else if (ffxx && a[7:4] == 4'h2) sel = SEL_IO1;
      else if (ffxx && a[7:5] == 3'd2) sel = SEL_IO2;
      else if (common) sel = SEL_RAM;
      else if (vec) sel = SEL_ROM1;
      else if (ffxx) sel = SEL_NONE;
      else if (!all_ram && a[15:13] == 3'd4) sel = SEL_ROM0;
      else if (!all_ram && a[15:13] == 3'd5) sel = SEL_ROM1;
      else if (!all_ram && a[15:14] == 2'd3) sel = SEL_ROM2;
      else sel = SEL_RAM;

      // register writes land before translation of the same word
      if (sreg && !rnw) begin
        case (reg_idx)
          REG_TASK:             task_sel  = a[0];
          REG_RATE0, REG_RATE1: fast_rate = a[0];
          REG_MAP:              all_ram   = a[0];
          default: ;
        endcase
      end
      if (ff3x && !rnw) begin
        if (!a[3]) pages[a[2:0]] = acc.data_in[PageW-1:0];
        else if (a[3:0] == PREG_COMMON) common_en = acc.data_in[1:0];
      end

      page = common ? PAGE_COMMON : pages[{task_sel, a[15:14]}];

      // interleave follows the rate from before this word
      if (!in_fast) begin
        if (!was_fast) begin
          ticks = TICKS_SLOW;
        end else begin
          ticks   = TICKS_TO_FAST;
          in_fast = 1'b1;
        end
      end else if (!was_fast) begin
        ticks    = ext_slow ? TICKS_TO_SLOW_X : TICKS_TO_SLOW;
        ext_slow = 1'b0;
        in_fast  = 1'b0;
      end else begin
        ticks    = TICKS_FAST;
        ext_slow = !ext_slow;
      end

      want.select_code    = sel;
      want.ram_address    = {page, a[OffsW-1:0]};
      want.ram_enable     = is_ram || common;
      want.write_enable_n = is_ram ? rnw : 1'b1;
      want.task_read      = rnw && sreg && (reg_idx == REG_TASK);
      want.task_bit       = task_sel;
      want.cycle_ticks    = ticks;
      expected_decodes.push_back(want);
    endfunction

    task flag_mismatch(string what);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("mismatch at word %0d: %s", words_seen, what);
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_result(result_t got);
      result_t want;
      words_seen++;
      if (expected_decodes.size() == 0) begin
        flag_mismatch($sformatf("unexpected word %p", got));
        return;
      end
      want = expected_decodes.pop_front();
      check_field("select_code", 32'(got.select_code), 32'(want.select_code));
      check_field("ram_address", 32'(got.ram_address), 32'(want.ram_address));
      check_field("ram_enable", 32'(got.ram_enable), 32'(want.ram_enable));
      check_field("write_enable_n", 32'(got.write_enable_n), 32'(want.write_enable_n));
      check_field("task_read", 32'(got.task_read), 32'(want.task_read));
      check_field("task_bit", 32'(got.task_bit), 32'(want.task_bit));
      check_field("cycle_ticks", 32'(got.cycle_ticks), 32'(want.cycle_ticks));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   steady;
  bit   rx_hold_req;
  int unsigned stuck_cycles;

  mapper_scoreboard sb = new();

  pbam_in_if  req_if ();
  pbam_out_if rsp_if ();

  paged_bus_address_mapper_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit take_gap();
    return !steady && ($urandom_range(99) < 35);
  endfunction

  function automatic logic [AddrW-1:0] ctrl_addr(logic [3:0] idx, logic val);
    return {11'h7FE, idx, val};
  endfunction

  function automatic logic [AddrW-1:0] page_addr(logic [3:0] idx);
    return {12'hFF3, idx};
  endfunction

  // Mostly register-area traffic and upper-page accesses, so the task, rate,
  // map type and page table keep moving; the rest is anywhere in the map.
  function automatic access_t pick_access();
    access_t     acc;
    int unsigned kind;
    kind               = $urandom_range(99);
    acc.read_not_write = 1'($urandom_range(1));
    acc.address        = 16'($urandom);
    acc.data_in        = 8'($urandom);
    if (kind < 20) begin
      acc.address[15:5]  = 11'h7FE;
      acc.read_not_write = ($urandom_range(3) == 0);
    end else if (kind < 35) begin
      acc.address[15:4]  = 12'hFF3;
      acc.read_not_write = ($urandom_range(3) == 0);
    end else if (kind < 50) begin
      acc.address[15:8] = 8'hFF;
    end else if (kind < 70) begin
      acc.address[15:13] = 3'b111;
    end
    return acc;
  endfunction

  task automatic send_word(input access_t acc);
    while (take_gap()) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid          <= 1'b1;
    req_if.read_not_write <= acc.read_not_write;
    req_if.address        <= acc.address;
    req_if.data_in        <= acc.data_in;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
  endtask

  task automatic do_access(input logic rnw, input logic [AddrW-1:0] addr,
                           input logic [DataW-1:0] data);
    access_t acc;
    acc.read_not_write = rnw;
    acc.address        = addr;
    acc.data_in        = data;
    send_word(acc);
  endtask

  task automatic wait_all_results();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // receiver side: random stalls, plus one long hold-off on request
  initial begin : rx_side
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES - 1) @(posedge clk_i);
      end else begin
        rsp_if.ready <= !take_gap();
      end
    end
  end

  // handshake monitor and stall watchdog
  always @(posedge clk_i) begin
    if (req_if.valid === 1'b1 && req_if.ready === 1'b1)
      sb.note_access('{req_if.read_not_write, req_if.address, req_if.data_in});
    if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
      sb.check_result('{rsp_if.select_code, rsp_if.ram_address, rsp_if.ram_enable,
                        rsp_if.write_enable_n, rsp_if.task_read, rsp_if.task_bit,
                        rsp_if.cycle_ticks});
    if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("FAIL paged_bus_address_mapper_top");
      $finish;
    end
  end

  initial begin : stimulus
    rst_ni                = 1'b0;
    steady                = 1'b0;
    rx_hold_req           = 1'b0;
    stuck_cycles          = 0;
    req_if.valid          = 1'b0;
    req_if.read_not_write = 1'b1;
    req_if.address        = '0;
    req_if.data_in        = '0;
    rsp_if.ready          = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // decode areas
    do_access(1'b0, 16'hFFFF, 8'hFF);              // vectors, write
    do_access(1'b1, 16'h8000, 8'h00);
    do_access(1'b1, 16'hA000, 8'h5A);
    do_access(1'b1, 16'hC000, 8'hA5);
    do_access(1'b1, 16'hFF00, 8'h00);
    do_access(1'b0, 16'hFF20, 8'h00);
    do_access(1'b1, 16'hFF40, 8'h00);
    // page table and common windows
    do_access(1'b0, page_addr(4'h7), 8'hFF);
    do_access(1'b0, page_addr(PREG_COMMON), 8'h03);
    do_access(1'b1, 16'hE123, 8'h00);
    do_access(1'b1, 16'hFFF0, 8'h00);
    do_access(1'b0, 16'hFEFF, 8'h00);
    // task bit set, then read back through the task register
    do_access(1'b0, ctrl_addr(REG_TASK, 1'b1), 8'h00);
    do_access(1'b1, ctrl_addr(REG_TASK, 1'b0), 8'h00);
    // all-RAM map type
    do_access(1'b0, ctrl_addr(REG_MAP, 1'b1), 8'h00);
    do_access(1'b0, 16'hC000, 8'h00);
    do_access(1'b0, ctrl_addr(REG_MAP, 1'b0), 8'h00);
    do_access(1'b0, page_addr(PREG_COMMON), 8'h00);
    // fast then slow with the extended slot
    do_access(1'b0, ctrl_addr(REG_RATE0, 1'b1), 8'h00);
    do_access(1'b1, 16'h1234, 8'h00);
    do_access(1'b0, ctrl_addr(REG_RATE0, 1'b0), 8'h00);
    do_access(1'b1, 16'h4000, 8'h00);
    // fast then slow without it
    do_access(1'b0, ctrl_addr(REG_RATE1, 1'b1), 8'h00);
    do_access(1'b1, 16'h7FFF, 8'h00);
    do_access(1'b1, 16'h2000, 8'h00);
    do_access(1'b0, ctrl_addr(REG_RATE1, 1'b0), 8'h00);
    do_access(1'b1, 16'h0000, 8'h00);
    wait_all_results();

    rx_hold_req = 1'b1;
    for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
      steady = (i >= 250 && i < 350);
      if (i == 420) wait_all_results();
      send_word(pick_access());
    end

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS paged_bus_address_mapper_top");
    end else begin
      $display("FAIL paged_bus_address_mapper_top");
    end
    $finish;
  end

endmodule
